### src/kepq_pkg.sv
package kepq_pkg;

  localparam logic [1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [1:0] CMD_PROCESS  = 2'd1;
  localparam logic [1:0] CMD_CANCEL   = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam int unsigned MAX_RESULTS = 16;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] cycle;
    logic [15:0] instance_id;
    logic [3:0]  handler_tag;
  } in_req_t;

  typedef struct packed {
    logic        fired_valid;
    logic [15:0] fired_instance;
    logic [3:0]  fired_handler;
    logic [63:0] fired_trigger;
    logic        is_last;
    logic [63:0] next_due;
    logic        pending;
    logic        overflow;
  } out_req_t;

  typedef struct packed {
    logic [63:0] trigger;
    logic [15:0] inst;
    logic [3:0]  handler;
  } slot_t;

endpackage

### src/keyed_event_priority_queue_core.sv
// Schedule and cancel run one scan pass (ST_SCAN), then ST_ACT, ST_LOAD and ST_EMIT.
// Process repeats the scan and ST_ACT (through ST_WAIT) once per removal, then the final
// pass goes on to ST_LOAD and ST_EMIT, which give one result per cycle while out_stall is low.
// Each pass is one scan of the slot memory, one entry read per cycle.
// One request is handled at a time; results wait in an output register.
// Reset (rst_n low, synchronous) clears the used bits and the control state.
module keyed_event_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kepq_pkg::in_req_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kepq_pkg::out_req_t   out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 2);
  localparam int RW = $clog2(kepq_pkg::MAX_RESULTS + 1);
  localparam int FW = $clog2(kepq_pkg::MAX_RESULTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_ACT   = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;

  // Slot memory: trigger, instance, handler. One read port, one write port.
  kepq_pkg::slot_t mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] used_r, used_nxt;

  // Fired events of one process request, in firing order.
  kepq_pkg::slot_t fbuf [kepq_pkg::MAX_RESULTS];
  kepq_pkg::slot_t fb_rd_r;
  logic            fb_we;

  logic [2:0]  state_r, state_nxt;
  kepq_pkg::in_req_t req_r;
  logic [CW-1:0] cnt_r, cnt_nxt;        // issue counter for the scan
  logic          rvld_r;                // read data valid this cycle
  logic [AW-1:0] raddr_r;               // address of the data now on rdata
  kepq_pkg::slot_t rdata_r;

  // Scan results
  logic          hit_r, hit_nxt;        // instance match (schedule/cancel) or best found
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic          free_r, free_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  kepq_pkg::slot_t best_r, best_nxt;
  logic [63:0]   min_r, min_nxt;        // earliest trigger among slots left after pass
  logic [RW-1:0] fired_r, fired_nxt;
  logic [RW-1:0] emit_idx_r, emit_idx_nxt;

  logic              ov_r, ov_nxt;
  kepq_pkg::out_req_t od_r, od_nxt;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  kepq_pkg::slot_t   wr_data;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          cur_used, due, better, is_proc, keyed;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign is_proc = (req_r.cmd == kepq_pkg::CMD_PROCESS);
  assign keyed   = (req_r.cmd == kepq_pkg::CMD_SCHEDULE) ||
                   (req_r.cmd == kepq_pkg::CMD_CANCEL);
  assign rd_en   = (state_r == ST_SCAN) && (cnt_r < CW'(QUEUE_DEPTH));
  assign rd_addr = cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fbuf[fired_r[FW-1:0]] <= best_r;
    end
    fb_rd_r <= fbuf[emit_idx_nxt[FW-1:0]];
  end

  always_comb begin
    cur_used = used_r[raddr_r];
    due      = rdata_r.trigger <= req_r.cycle;
    better   = !hit_r || (rdata_r.trigger < best_r.trigger) ||
               ((rdata_r.trigger == best_r.trigger) && (rdata_r.inst < best_r.inst));
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    cnt_nxt      = cnt_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    best_nxt     = best_r;
    min_nxt      = min_r;
    fired_nxt    = fired_r;
    emit_idx_nxt = emit_idx_r;
    ov_nxt       = ov_r;
    od_nxt       = od_r;
    wr_en        = 1'b0;
    wr_addr      = hit_idx_r;
    wr_data      = '0;
    fb_we        = 1'b0;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt    = ST_SCAN;
          cnt_nxt      = '0;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          min_nxt      = kepq_pkg::ALL_ONES;
          fired_nxt    = '0;
          emit_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (rvld_r) begin
          if (!cur_used) begin
            if (!free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = raddr_r;
            end
          end else if (is_proc) begin
            if (due && better) begin
              if (hit_r && best_r.trigger < min_nxt) begin
                min_nxt = best_r.trigger;
              end
              hit_nxt     = 1'b1;
              hit_idx_nxt = raddr_r;
              best_nxt    = rdata_r;
            end else if (rdata_r.trigger < min_r) begin
              min_nxt = rdata_r.trigger;
            end
          end else begin
            // matched slot is rewritten or dropped, so it stays out of min
            if (keyed && (rdata_r.inst == req_r.instance_id)) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = raddr_r;
            end else if (rdata_r.trigger < min_r) begin
              min_nxt = rdata_r.trigger;
            end
          end
        end
        if (cnt_r == CW'(QUEUE_DEPTH + 1)) begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        // min_r holds the earliest trigger of all used slots except the
        // matched or picked one. Apply the command and fix up min.
        state_nxt = ST_LOAD;
        case (req_r.cmd)
          kepq_pkg::CMD_SCHEDULE: begin
            if (hit_r || free_r) begin
              wr_en    = 1'b1;
              wr_addr  = hit_r ? hit_idx_r : free_idx_r;
              wr_data.trigger = req_r.cycle;
              wr_data.handler = req_r.handler_tag;
              wr_data.inst    = req_r.instance_id;
              used_nxt[wr_addr] = 1'b1;
              if (req_r.cycle < min_r) begin
                min_nxt = req_r.cycle;
              end
            end
          end
          kepq_pkg::CMD_PROCESS: begin
            if (hit_r) begin
              used_nxt[hit_idx_r] = 1'b0;
              if (best_r.handler != 4'd0) begin
                fb_we     = 1'b1;
                fired_nxt = fired_r + RW'(1);
              end
              if (fired_nxt != RW'(kepq_pkg::MAX_RESULTS)) begin
                state_nxt = ST_WAIT;  // rescan for the next due event
              end
            end
          end
          kepq_pkg::CMD_CANCEL: begin
            if (hit_r) begin
              used_nxt[hit_idx_r] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      ST_LOAD: begin
        // fire buffer read of entry zero lands in fb_rd_r
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          od_nxt = '0;
          od_nxt.pending  = |used_r;
          od_nxt.next_due = min_r;
          ov_nxt = 1'b1;
          if (fired_r == '0) begin
            od_nxt.overflow = (req_r.cmd == kepq_pkg::CMD_SCHEDULE) && !(hit_r || free_r);
            od_nxt.is_last  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            od_nxt.fired_valid    = 1'b1;
            od_nxt.fired_instance = fb_rd_r.inst;
            od_nxt.fired_handler  = fb_rd_r.handler;
            od_nxt.fired_trigger  = fb_rd_r.trigger;
            emit_idx_nxt = emit_idx_r + RW'(1);
            if (emit_idx_r == fired_r - RW'(1)) begin
              od_nxt.is_last = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_WAIT: begin
        state_nxt = ST_SCAN;
        cnt_nxt   = '0;
        hit_nxt   = 1'b0;
        min_nxt   = kepq_pkg::ALL_ONES;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      ov_r    <= 1'b0;
      rvld_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
      rvld_r  <= rd_en;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r <= in_data;
    end
    raddr_r    <= rd_addr;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    best_r     <= best_nxt;
    min_r      <= min_nxt;
    fired_r    <= fired_nxt;
    emit_idx_r <= emit_idx_nxt;
    od_r       <= od_nxt;
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.pending) |-> (out_data.next_due == kepq_pkg::ALL_ONES))
    else $error("empty queue with finite next_due");

endmodule

### sim/testbench.sv
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  kepq_pkg::in_req_t in_data;
  logic out_valid;
  logic out_stall;
  kepq_pkg::out_req_t out_data;

  keyed_event_priority_queue_core #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow copy of the event queue
  logic        q_used [DEPTH];
  logic [63:0] q_trig [DEPTH];
  logic [15:0] q_inst [DEPTH];
  logic [3:0]  q_tag  [DEPTH];

  kepq_pkg::out_req_t fired_q[$];     // results still owed by the block
  int mismatches = 0;
  int cycles = 0;
  bit idle_en;              // random gaps on both sides when set

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out every result one request will cause and queue them.
  task automatic predict_events(input kepq_pkg::in_req_t r);
    int s, best, count;
    logic ovf, pend;
    logic [63:0] due;
    kepq_pkg::out_req_t o;
    kepq_pkg::out_req_t batch[$];
    s = -1;
    count = 0;
    ovf = 1'b0;
    if (r.cmd == kepq_pkg::CMD_SCHEDULE) begin
      for (int i = 0; i < DEPTH; i++)
        if (s < 0 && q_used[i] && q_inst[i] == r.instance_id) s = i;
      if (s < 0) begin
        for (int i = 0; i < DEPTH; i++)
          if (s < 0 && !q_used[i]) s = i;
        if (s >= 0) begin
          q_used[s] = 1'b1;
          q_inst[s] = r.instance_id;
        end
      end
      if (s >= 0) begin
        q_trig[s] = r.cycle;
        q_tag[s] = r.handler_tag;
      end else ovf = 1'b1;
    end else if (r.cmd == kepq_pkg::CMD_PROCESS) begin
      while (count < kepq_pkg::MAX_RESULTS) begin
        best = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (q_used[i] && q_trig[i] <= r.cycle) begin
            if (best < 0 || q_trig[i] < q_trig[best] ||
                (q_trig[i] == q_trig[best] && q_inst[i] < q_inst[best]))
              best = i;
          end
        end
        if (best < 0) break;
        q_used[best] = 1'b0;
        if (q_tag[best] != 4'd0) begin
          o = '0;
          o.fired_valid = 1'b1;
          o.fired_instance = q_inst[best];
          o.fired_handler = q_tag[best];
          o.fired_trigger = q_trig[best];
          batch = {batch, o};
          count++;
        end
      end
    end else if (r.cmd == kepq_pkg::CMD_CANCEL) begin
      for (int i = 0; i < DEPTH; i++)
        if (q_used[i] && q_inst[i] == r.instance_id) q_used[i] = 1'b0;
    end
    due = kepq_pkg::ALL_ONES;
    pend = 1'b0;
    for (int i = 0; i < DEPTH; i++)
      if (q_used[i]) begin
        pend = 1'b1;
        if (q_trig[i] < due) due = q_trig[i];
      end
    if (batch.size() == 0) begin
      o = '0;
      o.overflow = ovf;
      batch = {batch, o};
    end
    foreach (batch[k]) begin
      batch[k].is_last = (k == batch.size() - 1);
      batch[k].next_due = due;
      batch[k].pending = pend;
      fired_q = {fired_q, batch[k]};
    end
  endtask

  // Send one request; gaps before it at random.
  task automatic send_request(input logic [1:0] cmd, input logic [63:0] cyc,
                              input logic [15:0] id, input logic [3:0] tag);
    kepq_pkg::in_req_t r;
    r.cmd = cmd;
    r.cycle = cyc;
    r.instance_id = id;
    r.handler_tag = tag;
    while (idle_en && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    predict_events(r);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stall, compare each accepted result with the oldest one owed.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= idle_en && ($urandom_range(99) < 25);
  end

  always @(posedge clk) begin
    kepq_pkg::out_req_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (fired_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_r = fired_q.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", exp_r, out_data);
        end
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("keyed_event_priority_queue_core regression: fail");
      $finish;
    end
  end

  // Wait until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (fired_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Directed: field extremes, every command, overflow, reschedule, ties, cmd three.
  task automatic test_directed();
    send_request(kepq_pkg::CMD_PROCESS, 64'd0, 16'd0, 4'd0);          // empty process
    send_request(kepq_pkg::CMD_SCHEDULE, 64'd100, 16'hFFFF, 4'hF);
    send_request(kepq_pkg::CMD_SCHEDULE, 64'd100, 16'h0000, 4'h1);    // tie, lower id
    send_request(kepq_pkg::CMD_SCHEDULE, 64'd50, 16'hFFFF, 4'h7);     // reschedule
    send_request(kepq_pkg::CMD_SCHEDULE, kepq_pkg::ALL_ONES, 16'h1234, 4'h0); // silent
    send_request(kepq_pkg::CMD_CANCEL, 64'd0, 16'h5555, 4'd0);        // absent instance
    send_request(kepq_pkg::CMD_NONE, rand64(), 16'hAAAA, 4'hA);       // unused command
    send_request(kepq_pkg::CMD_PROCESS, 64'd100, 16'd0, 4'd0);
    send_request(kepq_pkg::CMD_PROCESS, kepq_pkg::ALL_ONES, 16'hFFFF, 4'hF); // silent left
    for (int i = 0; i < DEPTH; i++)
      send_request(kepq_pkg::CMD_SCHEDULE, 64'd10 + (i % 3), 16'(i * 7), 4'(i));
    send_request(kepq_pkg::CMD_SCHEDULE, 64'd0, 16'hBEEF, 4'h3);      // full: overflow
    send_request(kepq_pkg::CMD_CANCEL, 64'd0, 16'd7, 4'd0);
    send_request(kepq_pkg::CMD_PROCESS, kepq_pkg::ALL_ONES, 16'd0, 4'd0); // drain all
    drain_results();
  endtask

  // Random: small id pool so reschedule, cancel hits and overflow are common.
  task automatic test_random(input int n_items, input bit gaps);
    int pick;
    logic [63:0] now;
    now = '0;
    idle_en = gaps;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 55)
        send_request(kepq_pkg::CMD_SCHEDULE,
                     ($urandom_range(9) == 0) ? rand64() : now + $urandom_range(40),
                     ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(23)),
                     4'($urandom()));
      else if (pick < 80) begin
        now = now + $urandom_range(30);
        send_request(kepq_pkg::CMD_PROCESS, ($urandom_range(19) == 0) ? rand64() : now,
                     16'($urandom()), 4'($urandom()));
      end else if (pick < 97)
        send_request(kepq_pkg::CMD_CANCEL, rand64(), 16'($urandom_range(23)),
                     4'($urandom()));
      else
        send_request(kepq_pkg::CMD_NONE, rand64(), 16'($urandom()), 4'($urandom()));
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_en = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      q_used[i] = 1'b0;
      q_trig[i] = '0;
      q_inst[i] = '0;
      q_tag[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(200, 1'b1);
    test_random(80, 1'b0);    // back-to-back stretch
    idle_en = 1'b1;
    repeat (4 * DEPTH + 20) @(negedge clk);
    if (mismatches == 0 && fired_q.size() == 0)
      $display("keyed_event_priority_queue_core regression: pass");
    else
      $display("keyed_event_priority_queue_core regression: fail");
    $finish;
  end

endmodule

### filelist.f
src/kepq_pkg.sv
src/keyed_event_priority_queue_core.sv
sim/testbench.sv
